@@ rtl/core/mbe_pkg.sv @@
package mbe_pkg;

	localparam int MAX_ITER   = 64;
	localparam int MAX_SIZE   = 4096;
	localparam int SIZE_RESET = 512;
	localparam int FRAC_BITS  = 28;
	localparam int SIZE_W     = 13;
	localparam int COORD_W    = 12;
	localparam int CNT_W      = $clog2(MAX_ITER + 1);
	localparam int Q_W        = 32;
	localparam int STEP_W     = FRAC_BITS + 3;
	localparam int STEP_RESET = (2 ** (STEP_W - 1)) / SIZE_RESET;
	localparam int OFS_W      = COORD_W + 2;
	localparam int PROD_W     = STEP_W + 1 + OFS_W;
	localparam int WIDE_W     = 2 * Q_W + 1 - FRAC_BITS;
	localparam int ESC_LIM    = 2 ** (FRAC_BITS + 1);
	localparam int REG_W      = 32;
	localparam int ADDR_W     = 3;

	localparam logic [31:0] ALPHA_BASE = 32'hFF00_0000;
	localparam logic signed [2*Q_W:0] SQ_LIM = (2 * Q_W + 1)'(1) << (2 * FRAC_BITS + 2);
	localparam logic REG_IMAGE_SIZE = 1'b0;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_row;
		logic [COORD_W-1:0] pixel_col;
	} pixel_t;

	typedef struct packed {
		logic [31:0]      colour_word;
		logic [CNT_W-1:0] iteration_count;
	} result_t;

	typedef struct packed {
		logic                  vld;
		logic                  esc;
		logic [CNT_W-1:0]      cnt;
		logic [CNT_W-1:0]      pass;
		logic signed [Q_W-1:0] cr;
		logic signed [Q_W-1:0] ci;
	} ring_ctl_t;

	typedef struct packed {
		ring_ctl_t             ctl;
		logic signed [Q_W-1:0] nr;
		logic signed [Q_W-1:0] ni;
	} slot_t;

endpackage

@@ rtl/core/mbe_step_div.sv @@
module mbe_step_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic [mbe_pkg::SIZE_W-1:0] divisor,
	output logic [mbe_pkg::STEP_W-1:0] step,
	output logic                       run
);
	import mbe_pkg::*;

	localparam int IDX_W = $clog2(STEP_W);
	localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(STEP_W - 1);

	logic              run_q;
	logic [IDX_W-1:0]  idx_q;
	logic [SIZE_W-1:0] rem_q;
	logic [SIZE_W-1:0] dsr_q;
	logic [STEP_W-1:0] quo_q;
	logic [SIZE_W:0]   trial;
	logic              ge;

	assign trial = {rem_q, idx_q == IDX_TOP};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			idx_q <= '0;
			quo_q <= STEP_W'(STEP_RESET);
		end else if (load) begin
			run_q <= divisor != '0;
			idx_q <= IDX_TOP;
			quo_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[STEP_W-2:0], ge};
			if (idx_q == '0) begin
				run_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? SIZE_W'(trial - {1'b0, dsr_q}) : trial[SIZE_W-1:0];
		end
	end

	assign step = quo_q;
	assign run  = run_q;

endmodule

@@ rtl/core/mbe_ring.sv @@
module mbe_ring (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mbe_pkg::slot_t            entry,
	output logic                      take,
	output logic                      exit_vld,
	output logic [mbe_pkg::CNT_W-1:0] exit_cnt
);
	import mbe_pkg::*;

	localparam logic signed [WIDE_W:0] R_HI = (WIDE_W + 1)'(ESC_LIM);
	localparam logic signed [WIDE_W:0] R_LO = -R_HI;

	slot_t                    feed;
	ring_ctl_t                ctl_s1, ctl_s2, ctl_s3;
	ring_ctl_t                ctl_n2, ctl_n3;
	logic signed [2*Q_W-1:0]  pr_s1, pi_s1, px_s1;
	logic signed [2*Q_W:0]    sum_w, diff_w;
	logic                     esc_fine;
	logic                     esc_n;
	logic signed [WIDE_W-1:0] dr_s2, dx_s2;
	logic signed [WIDE_W:0]   nr_w, ni_w;
	logic                     coarse;
	logic                     last;
	logic signed [Q_W-1:0]    nr_s3, ni_s3;

	assign take = entry.ctl.vld && !ctl_s3.vld;
	assign feed = ctl_s3.vld ? slot_t'{ctl_s3, nr_s3, ni_s3} : entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= feed.ctl;
		end
	end

	always_ff @(posedge clk) begin
		pr_s1 <= feed.nr * feed.nr;
		pi_s1 <= feed.ni * feed.ni;
		px_s1 <= feed.nr * feed.ni;
	end

	assign sum_w    = (2 * Q_W + 1)'(pr_s1) + (2 * Q_W + 1)'(pi_s1);
	assign diff_w   = (2 * Q_W + 1)'(pr_s1) - (2 * Q_W + 1)'(pi_s1);
	assign esc_fine = sum_w > SQ_LIM;
	assign esc_n    = ctl_s1.esc || esc_fine;

	always_comb begin
		ctl_n2      = ctl_s1;
		ctl_n2.esc  = esc_n;
		ctl_n2.cnt  = esc_n ? ctl_s1.cnt : CNT_W'(ctl_s1.cnt + 1'b1);
		ctl_n2.pass = CNT_W'(ctl_s1.pass + 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_n2;
		end
	end

	always_ff @(posedge clk) begin
		dr_s2 <= diff_w[2*Q_W:FRAC_BITS];
		dx_s2 <= px_s1[2*Q_W-1:FRAC_BITS-1];
	end

	assign nr_w   = (WIDE_W + 1)'(dr_s2) + (WIDE_W + 1)'(ctl_s2.cr);
	assign ni_w   = (WIDE_W + 1)'(dx_s2) + (WIDE_W + 1)'(ctl_s2.ci);
	assign coarse = nr_w > R_HI || nr_w < R_LO || ni_w > R_HI || ni_w < R_LO;
	assign last   = ctl_s2.pass == CNT_W'(MAX_ITER);

	always_comb begin
		ctl_n3     = ctl_s2;
		ctl_n3.vld = ctl_s2.vld && !last;
		ctl_n3.esc = ctl_s2.esc || coarse;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3 <= ctl_n3;
		end
	end

	always_ff @(posedge clk) begin
		nr_s3 <= nr_w[Q_W-1:0];
		ni_s3 <= ni_w[Q_W-1:0];
	end

	assign exit_vld = ctl_s2.vld && last;
	assign exit_cnt = ctl_s2.cnt;

`ifndef NO_ASSERTIONS
	a_cnt_le_pass: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s2.vld |-> ctl_s2.cnt <= ctl_s2.pass)
		else $error("iteration count ahead of pass count");

	a_esc_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s1.vld && ctl_s1.esc) |=> (ctl_s2.vld && ctl_s2.esc))
		else $error("escaped slot lost its escape mark");
`endif

endmodule

@@ rtl/core/mandelbrot_escape_time_pixel_top.sv @@
// channel   handshake                  payload
// pixel     start / busy               pixel.pixel_row, pixel.pixel_col
// result    done (one-cycle strobe)    result.colour_word, result.iteration_count
// config    psel/penable/pwrite/pready paddr, pwdata, prdata (image_size at 0x0)
//
// An accepted pixel is scaled into a holding register and waits there until the ring has a free slot;
// every pixel then makes 64 passes through the three-stage iteration ring, so results leave in order.
// The ring holds three pixels; a new pixel can be accepted while earlier ones are still iterating.
// Writing a nonzero image_size runs the bit-serial step divider; busy stays high meanwhile.
// Reset sets image_size to 512 and the step to its matching value.
// done lasts one cycle; the receiver cannot hold results off.
module mandelbrot_escape_time_pixel_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  mbe_pkg::pixel_t            pixel,
	output logic                       done,
	output mbe_pkg::result_t           result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mbe_pkg::ADDR_W-1:0] paddr,
	input  logic [mbe_pkg::REG_W-1:0]  pwdata,
	output logic [mbe_pkg::REG_W-1:0]  prdata,
	output logic                       pready
);
	import mbe_pkg::*;

	localparam logic signed [PROD_W:0] SAT_HI  = (PROD_W + 1)'(2 ** (Q_W - 1) - 1);
	localparam logic signed [PROD_W:0] SAT_LO  = -SAT_HI - 1;
	localparam logic signed [PROD_W:0] HALF_Q  = (PROD_W + 1)'(2 ** (FRAC_BITS - 1));
	localparam logic signed [Q_W-1:0]  LIM_HI  = Q_W'(ESC_LIM);
	localparam logic signed [Q_W-1:0]  LIM_LO  = -LIM_HI;

	function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PROD_W:0] v);
		logic signed [Q_W-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[Q_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[Q_W-1:0];
		end else begin
			r = v[Q_W-1:0];
		end
		return r;
	endfunction

	logic                     cfg_wr;
	logic [SIZE_W-1:0]        size_wr;
	logic [SIZE_W-1:0]        size_q;
	logic [STEP_W-1:0]        step;
	logic                     div_run;
	logic                     accept;
	logic [COORD_W-1:0]       half;
	logic signed [OFS_W-1:0]  off_r, off_i;
	logic                     vld_s1;
	logic                     zero_s1;
	logic signed [PROD_W-1:0] prod_r_s1, prod_i_s1;
	logic signed [Q_W-1:0]    cr_w, ci_w;
	slot_t                    hold_q;
	logic                     take;
	logic                     exit_vld;
	logic [CNT_W-1:0]         exit_cnt;
	logic                     done_q;
	result_t                  result_q;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready && paddr[2] == REG_IMAGE_SIZE;
	assign size_wr = (pwdata[SIZE_W-1:0] > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE)
		: pwdata[SIZE_W-1:0];

	always_comb begin
		unique case (paddr[2])
			REG_IMAGE_SIZE: prdata = REG_W'(size_q);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(SIZE_RESET);
		end else if (cfg_wr) begin
			size_q <= size_wr;
		end
	end

	mbe_step_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (cfg_wr),
		.divisor (size_wr),
		.step    (step),
		.run     (div_run)
	);

	assign busy   = div_run || vld_s1 || hold_q.ctl.vld;
	assign accept = start && !busy;
	assign half   = size_q[SIZE_W-1:1];
	assign off_r  = OFS_W'({2'b00, pixel.pixel_col}) + OFS_W'(1) - OFS_W'({2'b00, half});
	assign off_i  = OFS_W'({2'b00, pixel.pixel_row}) + OFS_W'(1) - OFS_W'({2'b00, half});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_r_s1 <= $signed({1'b0, step}) * off_r;
			prod_i_s1 <= $signed({1'b0, step}) * off_i;
			zero_s1   <= size_q == '0;
		end
	end

	assign cr_w = sat_q((PROD_W + 1)'(prod_r_s1) - HALF_Q);
	assign ci_w = sat_q((PROD_W + 1)'(prod_i_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q.ctl.vld <= 1'b0;
		end else if (vld_s1) begin
			hold_q.ctl.vld  <= 1'b1;
			hold_q.ctl.esc  <= zero_s1 || cr_w > LIM_HI || cr_w < LIM_LO
				|| ci_w > LIM_HI || ci_w < LIM_LO;
			hold_q.ctl.cnt  <= '0;
			hold_q.ctl.pass <= '0;
			hold_q.ctl.cr   <= cr_w;
			hold_q.ctl.ci   <= ci_w;
			hold_q.nr       <= cr_w;
			hold_q.ni       <= ci_w;
		end else if (take) begin
			hold_q.ctl.vld <= 1'b0;
		end
	end

	mbe_ring u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.entry    (hold_q),
		.take     (take),
		.exit_vld (exit_vld),
		.exit_cnt (exit_cnt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= exit_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (exit_vld) begin
			result_q.colour_word     <= ALPHA_BASE + 32'({exit_cnt, 2'b00});
			result_q.iteration_count <= exit_cnt;
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef NO_ASSERTIONS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("pixel word accepted but block not busy");

	a_size_div: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && size_wr != '0) |=> busy)
		else $error("size write did not start step divider");
`endif

endmodule
